FILE: rtl/core/fnmf_pkg.sv
// Package for the four-neighbour mean filter: sizes, register indexes and shared types.
// Used by every module of the filter, the stream interfaces and the checker.
package fnmf_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int PIXEL_BITS_DEFAULT = 8;
    localparam int SIZE_BITS          = 11;
    localparam int ROW_BITS           = 10;
    localparam int MAX_HEIGHT         = 1024;
    localparam int SIZE_RESET         = 3;
    localparam int MEAN_BITS          = 16;
    localparam int FRAC_BITS          = 8;
    localparam int APB_DATA_BITS      = 32;
    localparam int APB_ADDR_BITS      = 3;
    localparam int COUNT_BITS         = 3;

    localparam logic [COUNT_BITS-1:0] COUNT_TWO   = 3'd2;
    localparam logic [COUNT_BITS-1:0] COUNT_THREE = 3'd3;
    localparam logic [COUNT_BITS-1:0] COUNT_FOUR  = 3'd4;

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic first_col;
        logic last_col;
        logic col_ge2;
        logic row_ge2;
    } pos_flags_t;

    typedef struct packed
    {
        logic [COUNT_BITS-1:0] count;
        logic                  last;
    } mean_ctl_t;

endpackage

FILE: rtl/core/fnmf_if.sv
// Valid/ready stream interfaces for the pixel input and the mean output.
// Depends on fnmf_pkg for the default widths.
interface fnmf_pixel_if #(parameter int PIXEL_BITS = fnmf_pkg::PIXEL_BITS_DEFAULT);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface fnmf_mean_if;
    logic                               valid;
    logic                               ready;
    logic [fnmf_pkg::MEAN_BITS-1:0]     mean_value;
    logic                               last;

    modport source (output valid, output mean_value, output last, input ready);
    modport sink (input valid, input mean_value, input last, output ready);
endinterface

FILE: rtl/core/four_neighbour_mean_filter.sv
// Four-neighbour mean filter over a raster-order pixel stream.
// Pixels enter on the sink channel "pixels"; means leave on the source channel "means",
// both valid/ready with a request moving when valid and ready are high at a clock edge.
// The image size is set over the APB port (width at 0x0, height at 0x4); a write restarts
// the frame and is to be made by the user only while the filter is idle, which the block
// does not enforce. Pixel (i,j) produces the mean of the pixel above it, so rows 1..H-1
// each produce the results of the row before; the last row also produces its own results,
// two requests per pixel after its first column and three for the final pixel (last = 1).
// A result is formed in the working stage from the pixel that completes it and is then
// registered for output. One pixel is taken per cycle in all rows but the last, while the
// receiver takes every result; in the last row the single output register, delivering at
// most one result per cycle, holds each pixel until all of its results are out.
// The line buffers are two read-first RAMs that swap roles at each row end; each sees one
// read and at most one write per accepted pixel.
// Reset clears the counters and the pipeline; line buffer contents are not cleared.
// A stalled receiver holds the output register; one pixel more is taken into the
// working stage, then pixels that owe a result back up.
module four_neighbour_mean_filter #(
    parameter int MAX_WIDTH  = fnmf_pkg::MAX_WIDTH_DEFAULT,
    parameter int PIXEL_BITS = fnmf_pkg::PIXEL_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fnmf_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [fnmf_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [fnmf_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    fnmf_pixel_if.sink                           pixels,
    fnmf_mean_if.source                          means
);
    import fnmf_pkg::*;

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);
    localparam int SUM_BITS   = PIXEL_BITS + 2;
    localparam int PEND_NORTH = 0;
    localparam int PEND_WEST  = 1;
    localparam int PEND_OWN   = 2;

    logic [WIDTH_BITS-1:0] image_width;
    logic [SIZE_BITS-1:0]  image_height;
    logic                  restart;

    logic [COL_BITS-1:0]   col_reg;
    logic [COL_BITS-1:0]   col_next;
    logic [COL_BITS-1:0]   col_plus1;
    logic [ROW_BITS-1:0]   row_reg;
    logic [ROW_BITS-1:0]   row_next;
    logic                  bank_sel_reg;
    logic                  bank_sel_next;

    logic                  accept;
    logic                  last_row;
    logic                  row_ge1;
    pos_flags_t            pos_flags;
    logic [2:0]            pend_new;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [2:0]            pend_reg;
    logic [2:0]            pend_next;
    logic [2:0]            pend_left;
    logic [2:0]            sel_mask;
    pos_flags_t            s1_flags_reg;
    logic                  s1_bank_reg;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;
    logic                  s1_done;
    logic                  load;

    logic [PIXEL_BITS-1:0] rd_a;
    logic [PIXEL_BITS-1:0] rd_b;
    logic [PIXEL_BITS-1:0] older_rd;
    logic [PIXEL_BITS-1:0] newer_rd;

    logic [PIXEL_BITS-1:0] win_west_reg;
    logic [PIXEL_BITS-1:0] win_mid_reg;
    logic [PIXEL_BITS-1:0] row_first_reg;
    logic [PIXEL_BITS-1:0] run_prev_reg;
    logic [PIXEL_BITS-1:0] run_prev2_reg;

    logic [SUM_BITS-1:0]   north_sum;
    logic [SUM_BITS-1:0]   west_sum;
    logic [SUM_BITS-1:0]   own_sum;
    mean_ctl_t             north_ctl;
    mean_ctl_t             west_ctl;
    mean_ctl_t             own_ctl;
    logic [SUM_BITS-1:0]   sel_sum;
    mean_ctl_t             sel_ctl;
    logic [MEAN_BITS-1:0]  sel_mean;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [MEAN_BITS-1:0]  out_mean_reg;
    logic                  out_last_reg;

    fnmf_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .WIDTH_BITS (WIDTH_BITS)
    ) u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .image_width  (image_width),
        .image_height (image_height),
        .restart      (restart)
    );

    assign accept    = pixels.valid & pixels.ready;
    assign col_plus1 = col_reg + COL_BITS'(1);

    assign pos_flags.first_col = (col_reg == '0);
    assign pos_flags.last_col  = (WIDTH_BITS'(col_reg) == image_width - WIDTH_BITS'(1));
    assign pos_flags.col_ge2   = (WIDTH_BITS'(col_reg) >= WIDTH_BITS'(2));
    assign pos_flags.row_ge2   = (row_reg >= ROW_BITS'(2));
    assign row_ge1             = (row_reg != '0);
    assign last_row            = (SIZE_BITS'(row_reg) == image_height - SIZE_BITS'(1));

    always_comb
    begin
        pend_new             = '0;
        pend_new[PEND_NORTH] = row_ge1;
        pend_new[PEND_WEST]  = last_row & ~pos_flags.first_col;
        pend_new[PEND_OWN]   = last_row & pos_flags.last_col;
    end

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        bank_sel_next = bank_sel_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (pos_flags.last_col)
            begin
                col_next      = '0;
                row_next      = last_row ? '0 : row_reg + ROW_BITS'(1);
                bank_sel_next = ~bank_sel_reg;
            end
            else
            begin
                col_next = col_plus1;
            end
        end
    end

    // Bank A is the older row while bank_sel_reg is low.
    fnmf_row_ram #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (PIXEL_BITS),
        .ADDR_BITS (COL_BITS)
    ) u_bank_a (
        .clk     (clk),
        .wr_en   (accept & ~bank_sel_reg),
        .wr_addr (col_reg),
        .wr_data (pixels.pixel),
        .rd_en   (accept),
        .rd_addr (bank_sel_reg ? col_plus1 : col_reg),
        .rd_data (rd_a)
    );

    fnmf_row_ram #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (PIXEL_BITS),
        .ADDR_BITS (COL_BITS)
    ) u_bank_b (
        .clk     (clk),
        .wr_en   (accept & bank_sel_reg),
        .wr_addr (col_reg),
        .wr_data (pixels.pixel),
        .rd_en   (accept),
        .rd_addr (bank_sel_reg ? col_reg : col_plus1),
        .rd_data (rd_b)
    );

    assign older_rd = s1_bank_reg ? rd_b : rd_a;
    assign newer_rd = s1_bank_reg ? rd_a : rd_b;

    always_comb
    begin
        north_sum = SUM_BITS'(s1_pixel_reg)
                  + (s1_flags_reg.row_ge2 ? SUM_BITS'(older_rd) : '0)
                  + (s1_flags_reg.first_col ? '0 : SUM_BITS'(win_west_reg))
                  + (s1_flags_reg.last_col ? '0 : SUM_BITS'(newer_rd));
        north_ctl.count = COUNT_BITS'(1) + COUNT_BITS'(s1_flags_reg.row_ge2)
                        + COUNT_BITS'(!s1_flags_reg.first_col)
                        + COUNT_BITS'(!s1_flags_reg.last_col);
        north_ctl.last  = 1'b0;

        west_sum = SUM_BITS'(s1_pixel_reg) + SUM_BITS'(win_west_reg)
                 + (s1_flags_reg.col_ge2 ? SUM_BITS'(run_prev2_reg) : '0);
        west_ctl.count = s1_flags_reg.col_ge2 ? COUNT_THREE : COUNT_TWO;
        west_ctl.last  = 1'b0;

        own_sum       = SUM_BITS'(win_mid_reg) + SUM_BITS'(run_prev_reg);
        own_ctl.count = COUNT_TWO;
        own_ctl.last  = 1'b1;
    end

    always_comb
    begin
        sel_mask = '0;
        if (pend_reg[PEND_NORTH])
        begin
            sel_mask[PEND_NORTH] = 1'b1;
            sel_sum              = north_sum;
            sel_ctl              = north_ctl;
        end
        else if (pend_reg[PEND_WEST])
        begin
            sel_mask[PEND_WEST] = 1'b1;
            sel_sum             = west_sum;
            sel_ctl             = west_ctl;
        end
        else
        begin
            sel_mask[PEND_OWN] = 1'b1;
            sel_sum            = own_sum;
            sel_ctl            = own_ctl;
        end
    end

    fnmf_mean_unit #(
        .SUM_BITS (SUM_BITS)
    ) u_mean_unit (
        .neighbour_sum   (sel_sum),
        .neighbour_count (sel_ctl.count),
        .mean_value      (sel_mean)
    );

    assign load         = s1_valid_reg & (|pend_reg) & (~out_valid_reg | means.ready);
    assign pend_left    = load ? (pend_reg & ~sel_mask) : pend_reg;
    assign s1_done      = s1_valid_reg & (pend_left == '0);
    assign pixels.ready = ~s1_valid_reg | s1_done;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        pend_next     = pend_left;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            pend_next     = pend_new;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (means.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            bank_sel_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            bank_sel_reg  <= bank_sel_next;
            s1_valid_reg  <= s1_valid_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The window slides when the working item leaves; at a row end the next row's
    // column zero comes from the first pixel saved in the row just finished.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixels.pixel;
            s1_flags_reg <= pos_flags;
            s1_bank_reg  <= bank_sel_reg;
        end
        if (s1_done)
        begin
            win_west_reg  <= win_mid_reg;
            win_mid_reg   <= s1_flags_reg.last_col ? row_first_reg : newer_rd;
            run_prev2_reg <= run_prev_reg;
            run_prev_reg  <= s1_pixel_reg;
            if (s1_flags_reg.first_col)
            begin
                row_first_reg <= s1_pixel_reg;
            end
        end
        if (load)
        begin
            out_mean_reg <= sel_mean;
            out_last_reg <= sel_ctl.last;
        end
    end

    assign means.valid      = out_valid_reg;
    assign means.mean_value = out_mean_reg;
    assign means.last       = out_last_reg;

endmodule

FILE: rtl/core/fnmf_row_ram.sv
// One line buffer: single write port, single registered read port, read-first.
// Depends on fnmf_pkg for its default sizes; sized by the instantiating module.
module fnmf_row_ram #(
    parameter int DEPTH     = fnmf_pkg::MAX_WIDTH_DEFAULT,
    parameter int DATA_BITS = fnmf_pkg::PIXEL_BITS_DEFAULT,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] row_mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= row_mem[rd_addr];
        end
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/fnmf_cfg_regs.sv
// APB register block holding the image width and height, clamped to their legal ranges.
// Depends on fnmf_pkg; any write restarts the frame.
module fnmf_cfg_regs #(
    parameter int MAX_WIDTH  = fnmf_pkg::MAX_WIDTH_DEFAULT,
    parameter int WIDTH_BITS = $clog2(MAX_WIDTH + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fnmf_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [fnmf_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [fnmf_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output logic [WIDTH_BITS-1:0]                image_width,
    output logic [fnmf_pkg::SIZE_BITS-1:0]       image_height,
    output logic                                 restart
);
    import fnmf_pkg::*;

    localparam int WIDTH_RESET = (SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET;

    logic [WIDTH_BITS-1:0] width_reg;
    logic [WIDTH_BITS-1:0] width_next;
    logic [SIZE_BITS-1:0]  height_reg;
    logic [SIZE_BITS-1:0]  height_next;
    logic [SIZE_BITS-1:0]  wr_value;
    logic                  wr_strobe;
    reg_index_t            reg_index;

    assign wr_strobe = psel & penable & pwrite;
    assign reg_index = reg_index_t'(paddr[2]);
    assign wr_value  = pwdata[SIZE_BITS-1:0];

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_strobe)
        begin
            case (reg_index)
                REG_IMAGE_WIDTH:
                begin
                    if (wr_value < SIZE_BITS'(2))
                    begin
                        width_next = WIDTH_BITS'(2);
                    end
                    else if (32'(wr_value) > 32'(MAX_WIDTH))
                    begin
                        width_next = WIDTH_BITS'(MAX_WIDTH);
                    end
                    else
                    begin
                        width_next = WIDTH_BITS'(wr_value);
                    end
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (wr_value < SIZE_BITS'(2))
                    begin
                        height_next = SIZE_BITS'(2);
                    end
                    else if (wr_value > SIZE_BITS'(MAX_HEIGHT))
                    begin
                        height_next = SIZE_BITS'(MAX_HEIGHT);
                    end
                    else
                    begin
                        height_next = wr_value;
                    end
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_BITS'(WIDTH_RESET);
            height_reg <= SIZE_BITS'(SIZE_RESET);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(height_reg);
            default:          prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign image_width  = width_reg;
    assign image_height = height_reg;
    assign restart      = wr_strobe;

endmodule

FILE: rtl/core/fnmf_mean_unit.sv
// Scales a neighbour sum by 256 and divides it by a count of 2, 3 or 4, truncating.
// Depends on fnmf_pkg; division by three is a multiply by a rounded-up reciprocal.
module fnmf_mean_unit #(
    parameter int SUM_BITS = fnmf_pkg::PIXEL_BITS_DEFAULT + 2
) (
    input  logic [SUM_BITS-1:0]                neighbour_sum,
    input  logic [fnmf_pkg::COUNT_BITS-1:0]    neighbour_count,
    output logic [fnmf_pkg::MEAN_BITS-1:0]     mean_value
);
    import fnmf_pkg::*;

    localparam int X_BITS    = SUM_BITS + FRAC_BITS;
    localparam int SHIFT     = X_BITS + 2;
    localparam int PROD_BITS = X_BITS + SHIFT;
    localparam int WIDE_BITS = (X_BITS > MEAN_BITS) ? X_BITS : MEAN_BITS;
    localparam longint unsigned RECIP_THREE = ((64'd1 << SHIFT) + 64'd2) / 64'd3;

    logic [X_BITS-1:0]    scaled;
    logic [PROD_BITS-1:0] product;
    logic [X_BITS-1:0]    quotient;
    logic [WIDE_BITS-1:0] quotient_wide;

    assign scaled  = {neighbour_sum, FRAC_BITS'(0)};
    assign product = PROD_BITS'(scaled) * PROD_BITS'(RECIP_THREE);

    always_comb
    begin
        case (neighbour_count)
            COUNT_TWO:   quotient = scaled >> 1;
            COUNT_THREE: quotient = product[PROD_BITS-1:SHIFT];
            COUNT_FOUR:  quotient = scaled >> 2;
            default:     quotient = scaled >> 2;
        endcase
    end

    assign quotient_wide = WIDE_BITS'(quotient);
    assign mean_value    = quotient_wide[MEAN_BITS-1:0];

endmodule

FILE: rtl/core/fnmf_checker.sv
// Port-level assertions for the four-neighbour mean filter, bound to its top level.
// Depends on fnmf_pkg for the result width.
module fnmf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [fnmf_pkg::MEAN_BITS-1:0]   out_mean,
    input logic                             out_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_mean) && $stable(out_last))
        else $error("stalled result changed");

    a_rise_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without a preceding pixel request");

    a_last_isolated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !(out_valid && out_last))
        else $error("two frame-end results in a row");

endmodule

bind four_neighbour_mean_filter fnmf_checker u_fnmf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixels.valid),
    .in_ready  (pixels.ready),
    .out_valid (means.valid),
    .out_ready (means.ready),
    .out_mean  (means.mean_value),
    .out_last  (means.last)
);

FILE: sim/tb_four_neighbour_mean_filter.sv
`timescale 1ns / 100ps
// Self-checking testbench for four_neighbour_mean_filter: drives pixel frames and APB size
// writes, predicts every neighbour mean and compares each output request in order.
// Depends on fnmf_pkg and the stream interfaces in fnmf_if.sv.
module tb_four_neighbour_mean_filter;
    import fnmf_pkg::*;

    typedef struct packed
    {
        logic [MEAN_BITS-1:0] mean_value;
        logic                 last;
    } mean_result_t;

    class mean_scoreboard;
        int unsigned    width;
        int unsigned    height;
        int unsigned    col;
        int unsigned    row;
        bit             bank;
        logic [7:0]     line_mem [2][MAX_WIDTH_DEFAULT];
        mean_result_t   expected_means [$];
        int unsigned    errors;

        function new();
            width  = SIZE_RESET;
            height = SIZE_RESET;
            col    = 0;
            row    = 0;
            bank   = 1'b0;
            errors = 0;
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned hi);
            if (v < 2)
                return 2;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void apply_register(reg_index_t idx, logic [APB_DATA_BITS-1:0] value);
            int unsigned v;
            v = value[SIZE_BITS-1:0];
            if (idx == REG_IMAGE_WIDTH)
                width = clamp_size(v, MAX_WIDTH_DEFAULT);
            else
                height = clamp_size(v, MAX_HEIGHT);
            col = 0;
            row = 0;
        endfunction

        function void push_mean(int unsigned sum, int unsigned cnt, bit last);
            mean_result_t m;
            m.mean_value = MEAN_BITS'((sum << FRAC_BITS) / cnt);
            m.last       = last;
            expected_means.push_back(m);
        endfunction

        // The newer bank holds row r-1; the older bank holds row r-2 ahead of the
        // current column and row r behind it.
        function void note_pixel(logic [7:0] px);
            int unsigned sum;
            int unsigned cnt;
            bit          older;
            older = !bank;
            if (row >= 1)
            begin
                sum = px;
                cnt = 1;
                if (row >= 2)
                begin
                    sum += line_mem[older][col];
                    cnt++;
                end
                if (col > 0)
                begin
                    sum += line_mem[bank][col-1];
                    cnt++;
                end
                if (col + 1 < width)
                begin
                    sum += line_mem[bank][col+1];
                    cnt++;
                end
                push_mean(sum, cnt, 1'b0);
            end
            line_mem[older][col] = px;
            if (row == height - 1)
            begin
                if (col >= 1)
                begin
                    sum = px + line_mem[bank][col-1];
                    cnt = 2;
                    if (col >= 2)
                    begin
                        sum += line_mem[older][col-2];
                        cnt++;
                    end
                    push_mean(sum, cnt, 1'b0);
                end
                if (col == width - 1)
                    push_mean(line_mem[bank][col] + line_mem[older][col-1], 2, 1'b1);
            end
            if (col == width - 1)
            begin
                bank = !bank;
                col  = 0;
                row  = (row == height - 1) ? 0 : row + 1;
            end
            else
            begin
                col++;
            end
        endfunction

        function void check_mean(logic [MEAN_BITS-1:0] mean_value, logic last);
            mean_result_t m;
            if (expected_means.size() == 0)
            begin
                errors++;
                $error("unexpected request: mean_value %0d last %0d", mean_value, last);
                return;
            end
            m = expected_means.pop_front();
            if (m.mean_value !== mean_value)
            begin
                errors++;
                $error("mean_value: expected %0d, actual %0d", m.mean_value, mean_value);
            end
            if (m.last !== last)
            begin
                errors++;
                $error("last: expected %0d, actual %0d", m.last, last);
            end
        endfunction

        function int unsigned pending();
            return expected_means.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    bit                       in_burst;
    bit                       out_burst;
    mean_scoreboard           sb = new();

    fnmf_pixel_if #(.PIXEL_BITS(PIXEL_BITS_DEFAULT)) pix_bus ();
    fnmf_mean_if                                     mean_bus ();

    four_neighbour_mean_filter uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pixels  (pix_bus),
        .means   (mean_bus)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && mean_bus.valid && mean_bus.ready)
            sb.check_mean(mean_bus.mean_value, mean_bus.last);
    end

    initial
    begin
        int unsigned stall;
        mean_bus.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = out_burst ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                mean_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            mean_bus.ready <= 1'b1;
            @(posedge clk);
            while (!mean_bus.valid)
                @(posedge clk);
        end
    end

    function automatic logic [7:0] draw_pixel();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] px);
        int unsigned gap;
        gap = in_burst ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.pixel <= px;
        @(posedge clk);
        while (!pix_bus.ready)
            @(posedge clk);
        sb.note_pixel(px);
    endtask

    task automatic pause_until_drained();
        pix_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Row-0 pixels raise no request, so the filter may still be busy once the
    // queue is empty; settle lets it go idle before a size write.
    task automatic settle();
        pause_until_drained();
        repeat (10) @(posedge clk);
    endtask

    task automatic send_stream(input int unsigned n);
        for (int unsigned k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 39) == 0)
                pause_until_drained();
            send_pixel(draw_pixel());
        end
    endtask

    task automatic write_register(input reg_index_t idx, input logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.apply_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [7:0]  corner_frame [9] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                                          8'hFF, 8'hFF, 8'hFF, 8'hFF};
        logic [7:0]  tiny_frame [4]   = '{8'h00, 8'hAA, 8'h55, 8'hFF};
        int unsigned random_items;
        int unsigned frame_size;
        int unsigned n;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        pix_bus.valid = 1'b0;
        pix_bus.pixel = '0;
        in_burst      = 1'b0;
        out_burst     = 1'b0;
        random_items  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset size is 3 x 3: corners, borders and a zero centre that must not count.
        for (int k = 0; k < 9; k++)
        begin
            if (k == 5)
                pause_until_drained();
            send_pixel(corner_frame[k]);
        end
        settle();

        // Sizes below the legal range are used as the minimum frame of 2 x 2.
        write_register(REG_IMAGE_WIDTH, 0);
        write_register(REG_IMAGE_HEIGHT, 1);
        foreach (tiny_frame[k])
            send_pixel(tiny_frame[k]);
        settle();

        while (random_items < 80)
        begin
            in_burst  = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: write_register(REG_IMAGE_WIDTH, $urandom_range(2, 9));
                1: write_register(REG_IMAGE_HEIGHT, $urandom_range(2, 5));
                2:
                begin
                    write_register(REG_IMAGE_HEIGHT, $urandom_range(0, 5));
                    write_register(REG_IMAGE_WIDTH, $urandom_range(0, 9));
                end
                default:
                begin
                    write_register(REG_IMAGE_WIDTH,
                                   {21'($urandom), 11'($urandom_range(0, 9))});
                    write_register(REG_IMAGE_HEIGHT,
                                   {21'($urandom), 11'($urandom_range(0, 5))});
                end
            endcase
            frame_size = sb.width * sb.height;
            // A partial frame is cut short by the next size write.
            if ($urandom_range(0, 3) == 0)
                n = $urandom_range(1, frame_size - 1);
            else
                n = frame_size * $urandom_range(1, 2);
            send_stream(n);
            random_items += n;
            settle();
        end

        // Out-of-range sizes are clamped; these frames are only started, not completed.
        in_burst  = 1'b0;
        out_burst = 1'b0;
        write_register(REG_IMAGE_WIDTH, 2047);
        write_register(REG_IMAGE_HEIGHT, 2);
        send_stream(8);
        settle();

        write_register(REG_IMAGE_WIDTH, 1);
        write_register(REG_IMAGE_HEIGHT, 32'hFFFF_FFFF);
        send_stream(8);
        pause_until_drained();
        repeat (20) @(posedge clk);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: files.f
rtl/core/fnmf_pkg.sv
rtl/core/fnmf_if.sv
rtl/core/fnmf_row_ram.sv
rtl/core/fnmf_cfg_regs.sv
rtl/core/fnmf_mean_unit.sv
rtl/core/four_neighbour_mean_filter.sv
rtl/core/fnmf_checker.sv
sim/tb_four_neighbour_mean_filter.sv
